[sv/pdr_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the arctangent table for the planar
// dead-reckoning integrator. No dependencies.
package pdr_pkg;

   localparam int ROTATION_STEPS = 16;
   localparam int ANGLE_TABLE_LEN = 24;
   localparam int ROT_ITERS = (ROTATION_STEPS > ANGLE_TABLE_LEN) ?
                              ANGLE_TABLE_LEN : ROTATION_STEPS;
   localparam int STEP_W = $clog2(ANGLE_TABLE_LEN);

   localparam int LEN_W  = 33;
   localparam int PROD_W = 64;
   localparam int XY_W   = 34;
   localparam int Z_W    = 33;
   localparam int SUM_W  = 35;

   localparam logic [15:0] STEP_TIME_RESET = 16'd410;
   localparam logic signed [PROD_W-1:0] GAIN_Q30   = 64'sd652032874;
   localparam logic signed [PROD_W-1:0] ROUND_Q29  = 64'sd536870912;
   localparam logic signed [Z_W-1:0]    PI_Q29     = 33'sd1686629713;
   localparam logic signed [Z_W-1:0]    HALF_PI_Q29 = 33'sd843314857;

   typedef struct packed {
      logic signed [15:0] speed;
      logic signed [15:0] depth_in;
      logic signed [15:0] roll_in;
      logic signed [15:0] pitch_in;
      logic signed [15:0] heading_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [15:0] pos_z;
      logic signed [15:0] roll_out;
      logic signed [15:0] pitch_out;
      logic signed [15:0] heading_out;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LENGTH,
      ST_GAIN,
      ST_PREROT,
      ST_ROTATE,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic              load;
      logic              mul_length;
      logic              mul_gain;
      logic              prerotate;
      logic              rotate;
      logic              commit;
      logic [STEP_W-1:0] step_idx;
   } cmd_type;

   function automatic logic signed [Z_W-1:0] atan_q29(input logic [STEP_W-1:0] idx);
      logic signed [Z_W-1:0] v;
      case (idx)
         5'd0:    v = 33'sd421657428;
         5'd1:    v = 33'sd248918915;
         5'd2:    v = 33'sd131521918;
         5'd3:    v = 33'sd66762579;
         5'd4:    v = 33'sd33510843;
         5'd5:    v = 33'sd16771758;
         5'd6:    v = 33'sd8387925;
         5'd7:    v = 33'sd4194219;
         5'd8:    v = 33'sd2097141;
         5'd9:    v = 33'sd1048575;
         5'd10:   v = 33'sd524288;
         5'd11:   v = 33'sd262144;
         5'd12:   v = 33'sd131072;
         5'd13:   v = 33'sd65536;
         5'd14:   v = 33'sd32768;
         5'd15:   v = 33'sd16384;
         5'd16:   v = 33'sd8192;
         5'd17:   v = 33'sd4096;
         5'd18:   v = 33'sd2048;
         5'd19:   v = 33'sd1024;
         5'd20:   v = 33'sd512;
         5'd21:   v = 33'sd256;
         5'd22:   v = 33'sd128;
         5'd23:   v = 33'sd64;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

[sv/pdr_controller.sv]
`timescale 1ns / 1ps
// Sequencing state machine for the dead-reckoning integrator: issues datapath
// commands and owns the result valid flag. Depends on pdr_pkg.
module pdr_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pdr_pkg::cmd_type  cmd
);
   import pdr_pkg::*;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              last_step;
   logic              out_free;

   assign last_step = (step_ff == STEP_W'(ROT_ITERS - 1));
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_LENGTH;
         ST_LENGTH: state_in = ST_GAIN;
         ST_GAIN:   state_in = ST_PREROT;
         ST_PREROT: state_in = ST_ROTATE;
         ST_ROTATE: if (last_step) state_in = ST_COMMIT;
         ST_COMMIT: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.step_idx = step_ff;
      req_stall    = 1'b1;
      step_in      = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_LENGTH: cmd.mul_length = 1'b1;
         ST_GAIN:   cmd.mul_gain = 1'b1;
         ST_PREROT: begin
            cmd.prerotate = 1'b1;
            step_in       = '0;
         end
         ST_ROTATE: begin
            cmd.rotate = 1'b1;
            step_in    = step_ff + 1'b1;
         end
         ST_COMMIT: cmd.commit = out_free;
         default:   req_stall = 1'b1;
      endcase
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[sv/pdr_datapath.sv]
`timescale 1ns / 1ps
// Datapath of the dead-reckoning integrator: step length multiply, gain
// scaling, iterative rotation, saturating position update. Depends on pdr_pkg.
module pdr_datapath (
   input  logic              clock,
   input  logic              reset,
   input  pdr_pkg::cmd_type  cmd,
   input  logic              csr_wr_en,
   input  logic [15:0]       csr_wr_data,
   input  pdr_pkg::req_type  req_data,
   output pdr_pkg::rsp_type  rsp_data
);
   import pdr_pkg::*;

   logic [15:0]              step_time_ff;
   req_type                  sample_ff;
   logic signed [LEN_W-1:0]  len_ff, len_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [XY_W-1:0]   x_ff, x_in, y_ff, y_in;
   logic signed [Z_W-1:0]    z_ff, z_in;
   logic signed [31:0]       pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   rsp_type                  rsp_ff, rsp_in;

   logic signed [PROD_W-1:0] rounded;
   logic signed [XY_W-1:0]   scaled_len;
   logic signed [Z_W-1:0]    z_start;
   logic signed [XY_W-1:0]   x_shift, y_shift;
   logic signed [Z_W-1:0]    angle;
   logic signed [XY_W-1:0]   dx, dy;
   logic signed [SUM_W-1:0]  sum_x, sum_y;

   function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] s);
      logic signed [31:0] r;
      if (s > 35'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (s < -35'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = s[31:0];
      end
      return r;
   endfunction

   always_comb begin
      len_in  = sample_ff.speed * $signed({1'b0, step_time_ff});
      prod_in = len_ff * GAIN_Q30;

      rounded    = prod_ff + ROUND_Q29;
      scaled_len = rounded[PROD_W-1:30];
      z_start    = {sample_ff.heading_in[15], sample_ff.heading_in, 16'b0};

      x_shift = x_ff >>> cmd.step_idx;
      y_shift = y_ff >>> cmd.step_idx;
      angle   = atan_q29(cmd.step_idx);

      dx    = (x_ff + 34'sd8) >>> 4;
      dy    = (y_ff + 34'sd8) >>> 4;
      sum_x = SUM_W'(pos_x_ff) + SUM_W'(dx);
      sum_y = SUM_W'(pos_y_ff) + SUM_W'(dy);

      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      if (cmd.prerotate) begin
         y_in = '0;
         if (z_start > HALF_PI_Q29) begin
            x_in = -scaled_len;
            z_in = z_start - PI_Q29;
         end else if (z_start < -HALF_PI_Q29) begin
            x_in = -scaled_len;
            z_in = z_start + PI_Q29;
         end else begin
            x_in = scaled_len;
            z_in = z_start;
         end
      end else if (cmd.rotate) begin
         if (!z_ff[Z_W-1]) begin
            x_in = x_ff - y_shift;
            y_in = y_ff + x_shift;
            z_in = z_ff - angle;
         end else begin
            x_in = x_ff + y_shift;
            y_in = y_ff - x_shift;
            z_in = z_ff + angle;
         end
      end

      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      rsp_in   = rsp_ff;
      if (cmd.commit) begin
         pos_x_in           = sat32(sum_x);
         pos_y_in           = sat32(sum_y);
         rsp_in.pos_x       = pos_x_in;
         rsp_in.pos_y       = pos_y_in;
         rsp_in.pos_z       = sample_ff.depth_in;
         rsp_in.roll_out    = sample_ff.roll_in;
         rsp_in.pitch_out   = sample_ff.pitch_in;
         rsp_in.heading_out = sample_ff.heading_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_time_ff <= STEP_TIME_RESET;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            step_time_ff <= csr_wr_data;
         end
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_ff <= req_data;
      end
      if (cmd.mul_length) begin
         len_ff <= len_in;
      end
      if (cmd.mul_gain) begin
         prod_ff <= prod_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

[sv/planar_dead_reckoning_integrator.sv]
`timescale 1ns / 1ps
// Top level of the planar dead-reckoning integrator: joins the controller and
// the datapath. Depends on pdr_pkg, pdr_controller and pdr_datapath.
//
// Usage:
//   The req channel takes one sensor sample per transaction (speed, depth,
//   roll, pitch, heading). The rsp channel returns one transaction per
//   sample: the updated x and y position and the pass-through fields.
//   csr_wr_en with csr_wr_data writes the step time; write it only while the
//   block is idle.
//   Each accepted request passes through the length multiply, the gain
//   multiply, the pre-rotation, the rotation steps and the commit. The
//   result register is loaded at the commit, once that register is free.
//   A new sample is taken only after the previous one is committed; the
//   shared CORDIC stage runs one rotation step per cycle after the
//   two multiplies and the pre-rotation.
//   req_stall is low only while the engine is idle, including while a
//   finished result waits in the output register.
//   When rsp_stall holds a result, the next sample is processed up to the
//   position update, which waits until the pending result is taken.
//   Synchronous reset clears the position to zero, loads the default step
//   time and drops rsp_valid.
module planar_dead_reckoning_integrator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pdr_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pdr_pkg::rsp_type  rsp_data,
   input  logic              csr_wr_en,
   input  logic [15:0]       csr_wr_data
);
   import pdr_pkg::*;

   cmd_type cmd;

   pdr_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   pdr_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_data),
      .rsp_data    (rsp_data)
   );

endmodule

[sv/pdr_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the planar dead-reckoning integrator, bound to the
// top level. Depends on pdr_pkg.
module pdr_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input pdr_pkg::rsp_type  rsp_data
);
   import pdr_pkg::*;

   a_reset_clears_valid: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while engine busy");

   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !$rose(rsp_valid))
      else $error("result appeared one cycle after a request");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

endmodule

bind planar_dead_reckoning_integrator pdr_checker u_pdr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[test/pdr_position_checker.sv]
`timescale 1ns / 1ps
// Position checker for the planar dead-reckoning integrator testbench: watches the
// request, result and step-time ports, predicts every result transaction and compares.
// Depends on pdr_pkg for the payload types and the rotation step count.
module pdr_position_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  pdr_pkg::req_type  req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  pdr_pkg::rsp_type  rsp_data,
   input  logic              csr_wr_en,
   input  logic [15:0]       csr_wr_data,
   output int unsigned       fail_count,
   output int unsigned       outstanding
);
   import pdr_pkg::*;

   localparam int     CORDIC_STEPS = (ROTATION_STEPS > 24) ? 24 : ROTATION_STEPS;
   localparam longint CORDIC_GAIN  = 64'sd652032874;
   localparam longint PI_Z         = 64'sd1686629713;
   localparam longint HALF_PI_Z    = 64'sd843314857;
   localparam longint POS_MAX      = 64'sd2147483647;
   localparam longint POS_MIN      = -64'sd2147483648;

   longint      arctan_z [24];
   rsp_type     expected_fixes [$];
   logic [15:0] step_time;
   longint      track_x;
   longint      track_y;

   initial begin
      for (int i = 0; i < 24; i++)
         arctan_z[i] = longint'($atan(2.0 ** (-i)) * 536870912.0);
   end

   function automatic void cordic_delta(input logic signed [15:0] speed,
                                        input logic signed [15:0] heading,
                                        input logic [15:0] dt,
                                        output longint dx, output longint dy);
      longint len, x, y, z, xs, ys;
      len = longint'(speed) * longint'(dt);
      x = (len * CORDIC_GAIN + 64'sd536870912) >>> 30;
      y = 0;
      z = longint'(heading) * 65536;
      if (z > HALF_PI_Z) begin
         x = -x;
         z = z - PI_Z;
      end else if (z < -HALF_PI_Z) begin
         x = -x;
         z = z + PI_Z;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys;
            y = y + xs;
            z = z - arctan_z[i];
         end else begin
            x = x + ys;
            y = y - xs;
            z = z + arctan_z[i];
         end
      end
      dx = (x + 8) >>> 4;
      dy = (y + 8) >>> 4;
   endfunction

   function automatic longint clamp32(input longint v);
      if (v > POS_MAX)
         return POS_MAX;
      if (v < POS_MIN)
         return POS_MIN;
      return v;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t: %s got %0d expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      longint  dx, dy;
      if (reset) begin
         step_time = 16'd410;
         track_x = 0;
         track_y = 0;
         expected_fixes.delete();
         fail_count = 0;
         outstanding = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_fixes.size() == 0) begin
               report_mismatch("result transaction with nothing pending, pos_x",
                               rsp_data.pos_x, 0);
            end else begin
               want = expected_fixes.pop_front();
               if (rsp_data.pos_x !== want.pos_x)
                  report_mismatch("pos_x", rsp_data.pos_x, want.pos_x);
               if (rsp_data.pos_y !== want.pos_y)
                  report_mismatch("pos_y", rsp_data.pos_y, want.pos_y);
               if (rsp_data.pos_z !== want.pos_z)
                  report_mismatch("pos_z", rsp_data.pos_z, want.pos_z);
               if (rsp_data.roll_out !== want.roll_out)
                  report_mismatch("roll_out", rsp_data.roll_out, want.roll_out);
               if (rsp_data.pitch_out !== want.pitch_out)
                  report_mismatch("pitch_out", rsp_data.pitch_out, want.pitch_out);
               if (rsp_data.heading_out !== want.heading_out)
                  report_mismatch("heading_out", rsp_data.heading_out, want.heading_out);
            end
         end
         if (req_valid && !req_stall) begin
            cordic_delta(req_data.speed, req_data.heading_in, step_time, dx, dy);
            track_x = clamp32(track_x + dx);
            track_y = clamp32(track_y + dy);
            want.pos_x = track_x[31:0];
            want.pos_y = track_y[31:0];
            want.pos_z = req_data.depth_in;
            want.roll_out = req_data.roll_in;
            want.pitch_out = req_data.pitch_in;
            want.heading_out = req_data.heading_in;
            expected_fixes.push_back(want);
         end
         if (csr_wr_en)
            step_time = csr_wr_data;
         outstanding = expected_fixes.size();
      end
   end

endmodule

[test/planar_dead_reckoning_integrator_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the planar dead-reckoning integrator: drives directed and random
// sensor samples under several step times and gives the verdict.
// Depends on pdr_pkg, planar_dead_reckoning_integrator and pdr_position_checker.
module planar_dead_reckoning_integrator_tb;
   import pdr_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;
   int unsigned fail_count;
   int unsigned outstanding;
   int          burst_left;

   planar_dead_reckoning_integrator u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   pdr_position_checker u_position_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

   // The receiver alternates long clear stretches, long stalls and choppy stretches.
   initial begin
      int run;
      rsp_stall = 1'b0;
      forever begin
         case ($urandom_range(0, 3))
            0: begin
               rsp_stall = 1'b0;
               run = $urandom_range(50, 300);
            end
            1: begin
               rsp_stall = 1'b1;
               run = $urandom_range(1, 60);
            end
            default: begin
               rsp_stall = 1'($urandom_range(0, 1));
               run = $urandom_range(1, 8);
            end
         endcase
         repeat (run) @(negedge clock);
      end
   end

   function automatic logic signed [15:0] random_angle();
      logic signed [15:0] a;
      if ($urandom_range(0, 9) == 0)
         a = 16'($urandom);
      else
         a = 16'($urandom_range(0, 51472) - 25736);
      return a;
   endfunction

   function automatic req_type directed_sample(input int i);
      req_type s;
      case (i)
         0:       begin s.speed = 16'sd32767;  s.heading_in = 16'sd0;      end
         1:       begin s.speed = -16'sd32768; s.heading_in = 16'sd0;      end
         2:       begin s.speed = 16'sd0;      s.heading_in = 16'sd0;      end
         3:       begin s.speed = 16'sd1;      s.heading_in = 16'sd12867;  end
         4:       begin s.speed = -16'sd1;     s.heading_in = 16'sd12868;  end
         5:       begin s.speed = 16'sd32767;  s.heading_in = -16'sd12867; end
         6:       begin s.speed = 16'sd32767;  s.heading_in = -16'sd12868; end
         7:       begin s.speed = 16'sd32767;  s.heading_in = 16'sd25736;  end
         8:       begin s.speed = -16'sd32768; s.heading_in = -16'sd25736; end
         9:       begin s.speed = 16'sd32767;  s.heading_in = 16'sd32767;  end
         10:      begin s.speed = 16'sd32767;  s.heading_in = -16'sd32768; end
         default: begin s.speed = 16'sd256;    s.heading_in = 16'sd6434;   end
      endcase
      case (i % 4)
         0:       s.depth_in = 16'sd32767;
         1:       s.depth_in = -16'sd32768;
         2:       s.depth_in = 16'sd0;
         default: s.depth_in = -16'sd1;
      endcase
      case (i % 3)
         0: begin
            s.roll_in = 16'sd25736;
            s.pitch_in = -16'sd25736;
         end
         1: begin
            s.roll_in = -16'sd25736;
            s.pitch_in = 16'sd25736;
         end
         default: begin
            s.roll_in = 16'sd0;
            s.pitch_in = 16'sd0;
         end
      endcase
      return s;
   endfunction

   // A steady sample holds a large speed on one course so the position runs into a bound.
   function automatic req_type random_sample(input bit steady, input logic signed [15:0] course,
                                             input bit reverse);
      req_type s;
      s.depth_in = 16'($urandom);
      s.roll_in = random_angle();
      s.pitch_in = random_angle();
      if (steady) begin
         s.speed = reverse ? 16'(-$urandom_range(16000, 32767)) :
                             16'($urandom_range(16000, 32767));
         s.heading_in = 16'(course + $urandom_range(0, 400) - 200);
      end else begin
         case ($urandom_range(0, 7))
            0:       s.speed = 16'sd32767;
            1:       s.speed = -16'sd32768;
            2:       s.speed = 16'($urandom_range(0, 511) - 256);
            default: s.speed = 16'($urandom);
         endcase
         s.heading_in = random_angle();
      end
      return s;
   endfunction

   function automatic logic [15:0] phase_step_time(input int p);
      logic [15:0] v;
      case (p)
         0, 6:          v = 16'd1;
         1, 3, 7, 9:    v = 16'hFFFF;
         2:             v = 16'd0;
         5:             v = 16'd410;
         default:       v = 16'($urandom_range(1, 65535));
      endcase
      return v;
   endfunction

   function automatic logic signed [15:0] pick_course();
      logic signed [15:0] c;
      case ($urandom_range(0, 4))
         0:       c = 16'sd0;
         1:       c = 16'sd12868;
         2:       c = -16'sd12868;
         3:       c = 16'sd25536;
         default: c = -16'sd25536;
      endcase
      return c;
   endfunction

   task automatic send_sample(input req_type s);
      int gap;
      req_data = s;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 40);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) :
                      $urandom_range(4, 20);
      end
   endtask

   // The step time may only change while the block is idle.
   task automatic write_step_time(input logic [15:0] value);
      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (25) @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   initial begin
      logic signed [15:0] course;
      bit                 reverse;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      burst_left = 0;
      course = '0;
      reverse = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_step_time(16'hFFFF);
      for (int i = 0; i < 12; i++)
         send_sample(directed_sample(i));

      for (int p = 0; p < 10; p++) begin
         write_step_time(phase_step_time(p));
         for (int n = 0; n < 115; n++) begin
            if (n % 30 == 0) begin
               course = pick_course();
               reverse = 1'($urandom_range(0, 1));
            end
            send_sample(random_sample(p % 2 == 1, course, reverse));
         end
      end

      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (30) @(negedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

[sim.f]
sv/pdr_pkg.sv
sv/pdr_controller.sv
sv/pdr_datapath.sv
sv/planar_dead_reckoning_integrator.sv
sv/pdr_checker.sv
test/pdr_position_checker.sv
test/planar_dead_reckoning_integrator_tb.sv
